// ----- hdl/dchp_pkg.sv -----
// Shared types and character codes for the diff command header parser.
package dchp_pkg;

  // Line parsing phase.
  typedef enum logic [2:0] {
    PH_OLD_FIRST = 3'd0,
    PH_OLD_LAST  = 3'd1,
    PH_NEW_FIRST = 3'd2,
    PH_NEW_LAST  = 3'd3,
    PH_SKIP      = 3'd4
  } phase_e;

  // Command code of a result.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Error code of a result.
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_REVERSED = 3'd1,
    ERR_BAD_CMD  = 3'd2,
    ERR_EXTRA    = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_e;

  localparam int unsigned OUT_WIDTH = 24;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;

endpackage

// ----- hdl/diff_command_header_parser_unit.sv -----
// Top level of the normal-format diff command header parser.

// This block parses a diff command line such as "12,15c20,23" one character
// per transfer and gives one result on each newline: the old range, the
// command, the new range and an error code. It takes one character every
// clock cycle while in_ready_o is high; a character moves through an input
// register and one update stage into the result register.
// The only throughput limit is the result register: in_ready_o drops only
// when a character is waiting in the input register while a result is held
// and not taken. Missing digits count as zero, a range without a comma has
// equal first and last numbers, and the first error of a line is kept while
// the rest of the line up to its newline is dropped. On any error the four
// numbers read as zero and the command reads as none. Numbers accumulate
// in NUM_WIDTH bits and saturate with an overflow error; the output ports
// carry their low 24 bits.
module diff_command_header_parser_unit #(
  parameter int unsigned NUM_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [23:0]       first_old_o,
  output logic [23:0]       last_old_o,
  output dchp_pkg::cmd_e    command_o,
  output logic [23:0]       first_new_o,
  output logic [23:0]       last_new_o,
  output dchp_pkg::err_e    error_o
);
  import dchp_pkg::*;

  localparam int unsigned ProdWidth = NUM_WIDTH + 4;
  localparam logic [NUM_WIDTH-1:0] NumMax = {NUM_WIDTH{1'b1}};

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] ch_q, ch_d;

  // Line state.
  phase_e               phase_q, phase_d;
  logic [NUM_WIDTH-1:0] lo_q, lo_d;
  logic [NUM_WIDTH-1:0] hi_q, hi_d;
  logic                 comma_q, comma_d;
  logic [NUM_WIDTH-1:0] olo_q, olo_d;
  logic [NUM_WIDTH-1:0] ohi_q, ohi_d;
  cmd_e                 cmd_q, cmd_d;
  err_e                 err_q, err_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [23:0] first_old_q, first_old_d;
  logic [23:0] last_old_q, last_old_d;
  cmd_e        command_q, command_d;
  logic [23:0] first_new_q, first_new_d;
  logic [23:0] last_new_q, last_new_d;
  err_e        error_q, error_d;

  logic                 advance;
  logic                 process;
  logic                 emit;
  logic                 is_nl;
  logic                 is_dig;
  logic [NUM_WIDTH-1:0] acc_sel;
  logic [ProdWidth-1:0] prod;
  logic                 ovf;
  logic [NUM_WIDTH-1:0] hi_close;

  // Zero-extended copies of the numbers, so the 24-bit output view works
  // for any accumulator width.
  logic [NUM_WIDTH+OUT_WIDTH-1:0] olo_ext, ohi_ext, lo_ext, hi_ext;

  // The update stage moves whenever the result register is free or drains.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign process    = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    ch_d       = ch_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      if (in_valid_i) begin
        ch_d = ch_i;
      end
    end
  end

  assign is_nl  = (ch_q == CH_NL);
  assign is_dig = (ch_q inside {[CH_0:CH_9]});

  // First numbers build in the low accumulator, second numbers in the high.
  assign acc_sel = (phase_q == PH_OLD_FIRST || phase_q == PH_NEW_FIRST) ? lo_q : hi_q;
  assign prod = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
              + {{(ProdWidth - 4){1'b0}}, ch_q[3:0]};
  assign ovf  = (prod[ProdWidth-1:NUM_WIDTH] != 4'd0);

  // A range without a comma ends with its last number equal to its first.
  assign hi_close = comma_q ? hi_q : lo_q;

  // Next line state.
  always_comb begin
    phase_d = phase_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    comma_d = comma_q;
    olo_d   = olo_q;
    ohi_d   = ohi_q;
    cmd_d   = cmd_q;
    err_d   = err_q;
    emit    = 1'b0;
    if (process) begin
      case (phase_q)
        PH_OLD_FIRST, PH_OLD_LAST, PH_NEW_FIRST, PH_NEW_LAST: begin
          if (is_dig) begin
            if (ovf) begin
              if (phase_q == PH_OLD_FIRST || phase_q == PH_NEW_FIRST) begin
                lo_d = NumMax;
              end else begin
                hi_d = NumMax;
              end
              err_d   = ERR_OVERFLOW;
              phase_d = PH_SKIP;
            end else if (phase_q == PH_OLD_FIRST || phase_q == PH_NEW_FIRST) begin
              lo_d = prod[NUM_WIDTH-1:0];
            end else begin
              hi_d = prod[NUM_WIDTH-1:0];
            end
          end else if (ch_q == CH_COMMA &&
                       (phase_q == PH_OLD_FIRST || phase_q == PH_NEW_FIRST)) begin
            comma_d = 1'b1;
            hi_d    = '0;
            phase_d = (phase_q == PH_OLD_FIRST) ? PH_OLD_LAST : PH_NEW_LAST;
          end else if (phase_q == PH_OLD_FIRST || phase_q == PH_OLD_LAST) begin
            hi_d = hi_close;
            if (lo_q > hi_close) begin
              err_d   = ERR_REVERSED;
              phase_d = PH_SKIP;
              emit    = is_nl;
            end else if (ch_q inside {CH_A, CH_C, CH_D}) begin
              olo_d   = lo_q;
              ohi_d   = hi_close;
              cmd_d   = (ch_q == CH_A) ? CMD_APPEND :
                        (ch_q == CH_C) ? CMD_CHANGE : CMD_DELETE;
              lo_d    = '0;
              hi_d    = '0;
              comma_d = 1'b0;
              phase_d = PH_NEW_FIRST;
            end else begin
              err_d   = ERR_BAD_CMD;
              phase_d = PH_SKIP;
              emit    = is_nl;
            end
          end else begin
            // End of the new range: only a newline may follow it.
            hi_d = hi_close;
            if (lo_q > hi_close) begin
              err_d   = ERR_REVERSED;
              phase_d = PH_SKIP;
            end else if (!is_nl) begin
              err_d   = ERR_EXTRA;
              phase_d = PH_SKIP;
            end
            emit = is_nl;
          end
        end
        default: begin
          phase_d = PH_SKIP;
          emit    = is_nl;
        end
      endcase
    end
  end

  assign olo_ext = {{OUT_WIDTH{1'b0}}, olo_d};
  assign ohi_ext = {{OUT_WIDTH{1'b0}}, ohi_d};
  assign lo_ext  = {{OUT_WIDTH{1'b0}}, lo_d};
  assign hi_ext  = {{OUT_WIDTH{1'b0}}, hi_d};

  // Result register load.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    first_old_d = first_old_q;
    last_old_d  = last_old_q;
    command_d   = command_q;
    first_new_d = first_new_q;
    last_new_d  = last_new_q;
    error_d     = error_q;
    if (emit) begin
      out_valid_d = 1'b1;
      error_d     = err_d;
      if (err_d != ERR_OK) begin
        first_old_d = '0;
        last_old_d  = '0;
        command_d   = CMD_NONE;
        first_new_d = '0;
        last_new_d  = '0;
      end else begin
        first_old_d = olo_ext[OUT_WIDTH-1:0];
        last_old_d  = ohi_ext[OUT_WIDTH-1:0];
        command_d   = cmd_d;
        first_new_d = lo_ext[OUT_WIDTH-1:0];
        last_new_d  = hi_ext[OUT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_OLD_FIRST;
      lo_q        <= '0;
      hi_q        <= '0;
      comma_q     <= 1'b0;
      olo_q       <= '0;
      ohi_q       <= '0;
      cmd_q       <= CMD_NONE;
      err_q       <= ERR_OK;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        // A newline that gives a result starts a fresh line.
        phase_q <= PH_OLD_FIRST;
        lo_q    <= '0;
        hi_q    <= '0;
        comma_q <= 1'b0;
        olo_q   <= '0;
        ohi_q   <= '0;
        cmd_q   <= CMD_NONE;
        err_q   <= ERR_OK;
      end else begin
        phase_q <= phase_d;
        lo_q    <= lo_d;
        hi_q    <= hi_d;
        comma_q <= comma_d;
        olo_q   <= olo_d;
        ohi_q   <= ohi_d;
        cmd_q   <= cmd_d;
        err_q   <= err_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    ch_q        <= ch_d;
    first_old_q <= first_old_d;
    last_old_q  <= last_old_d;
    command_q   <= command_d;
    first_new_q <= first_new_d;
    last_new_q  <= last_new_d;
    error_q     <= error_d;
  end

  assign out_valid_o = out_valid_q;
  assign first_old_o = first_old_q;
  assign last_old_o  = last_old_q;
  assign command_o   = command_q;
  assign first_new_o = first_new_q;
  assign last_new_o  = last_new_q;
  assign error_o     = error_q;

  // The skip phase and a latched error always go together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) == (err_q != ERR_OK))
    else $error("skip phase and latched error disagree");

  // A failed line reports no command and zero ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o != ERR_OK |->
      command_o == CMD_NONE && first_old_o == '0 && last_old_o == '0 &&
      first_new_o == '0 && last_new_o == '0)
    else $error("error result carries range data");

  // A clean line always names a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o == ERR_OK |-> command_o != CMD_NONE)
    else $error("clean result without a command");

  // Input back-pressure only comes from a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && in_valid_q)
    else $error("input stalled without a held result");

  // A result can only follow a newline in the update stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> process && ch_q == CH_NL)
    else $error("result produced without a newline");

endmodule
